@@ hdl/mcd_pkg.sv @@
// Shared types and codes for the maze carver core.
package mcd_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;
  localparam int REG_W        = 6;
  localparam int LIM_W        = 9;
  localparam int POS_W        = 5;

  typedef enum logic [2:0] {
    EV_STARTED     = 3'd0,
    EV_CARVED      = 3'd1,
    EV_REJECTED    = 3'd2,
    EV_BACKTRACKED = 3'd3,
    EV_EXIT        = 3'd4,
    EV_FINISHED    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_WEST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_NORTH = 2'd3
  } dir_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DRAW  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

endpackage

@@ hdl/maze_carver_dfs_core.sv @@
// Maze carver top level: depth-first carving sequencer over visited map and path stack.
//
//  channel | signals                                          | direction
//  in      | in_valid, in_stall, command, direction           | word in
//  out     | out_valid, out_stall, event_res, cell_row,       | word out
//          | cell_col, wall_direction                         |
//  cfg     | cfg_we, cfg_index, cfg_data                      | write only
//
// Start word: a clearing sweep over all 2**(row bits + col bits) visited-map entries (1024 by default).
// Draw word while carving: look and decide, plus a pop step on a backtrack; the four neighbour reads
// share the single visited-map read port. Draw while idle: a decide step only.
// Reset is synchronous; the visited map is only read after a start has swept it.
// A stalled result holds the block in its last step; no new word is taken meanwhile.
module maze_carver_dfs_core #(
  parameter int MAX_ROWS = mcd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mcd_pkg::DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     command,
  input  logic [1:0]               direction,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               event_res,
  output logic [mcd_pkg::POS_W-1:0] cell_row,
  output logic [mcd_pkg::POS_W-1:0] cell_col,
  output logic [1:0]               wall_direction,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [mcd_pkg::REG_W-1:0] cfg_data
);
  import mcd_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int SW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_LOOK   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_POP    = 5'b10000
  } state_t;

  typedef struct packed {
    logic            ok;
    logic [RW-1:0]   row;
    logic [CW-1:0]   col;
  } nbr_t;

  state_t           state;
  logic [REG_W-1:0] maze_rows;
  logic [REG_W-1:0] maze_cols;
  logic [RW-1:0]    cur_row;
  logic [CW-1:0]    cur_col;
  logic [DW-1:0]    depth;
  logic             exit_opened;
  logic             active;
  logic [1:0]       dir;
  logic [2:0]       nb;
  logic             look_ok;
  logic [3:0]       openv;
  logic [AW-1:0]    clr_addr;

  logic             vis [0:(1<<AW)-1];
  logic [AW-1:0]    stk [0:CELLS-1];
  logic             vis_q;
  logic [AW-1:0]    stk_q;

  logic [LIM_W-1:0] rows_eff;
  logic [LIM_W-1:0] cols_eff;
  nbr_t             look_n;
  nbr_t             move_n;
  logic             can_emit;
  logic             in_acc;
  logic             vis_we;
  logic [AW-1:0]    vis_waddr;
  logic             vis_wdata;
  logic [AW-1:0]    vis_raddr;
  logic             stk_we;
  logic [SW-1:0]    stk_waddr;
  logic [AW-1:0]    stk_wdata;
  logic             stk_re;
  logic [SW-1:0]    stk_raddr;
  logic [DW-1:0]    depth_dec;
  logic [2:0]       nb_prev;
  logic             emit;
  event_t           ev;
  logic [1:0]       wall;

  function automatic logic [LIM_W-1:0] eff_limit(input logic [REG_W-1:0] v, input int maxv);
    logic [LIM_W-1:0] ve;
    ve = LIM_W'(v);
    if (v == '0) return LIM_W'(1);
    if (ve > LIM_W'(maxv)) return LIM_W'(maxv);
    return ve;
  endfunction

  function automatic nbr_t neighbour(input logic [1:0] d, input logic [RW-1:0] r,
                                     input logic [CW-1:0] c, input logic [LIM_W-1:0] rl,
                                     input logic [LIM_W-1:0] cl);
    logic [LIM_W-1:0] nr;
    logic [LIM_W-1:0] nc;
    nbr_t             n;
    nr = LIM_W'(r);
    nc = LIM_W'(c);
    unique case (dir_t'(d))
      DIR_EAST:  nc = nc + LIM_W'(1);
      DIR_WEST:  nc = nc - LIM_W'(1);
      DIR_SOUTH: nr = nr + LIM_W'(1);
      DIR_NORTH: nr = nr - LIM_W'(1);
      default:   nr = nr;
    endcase
    n.ok  = (nr < rl) && (nc < cl);
    n.row = nr[RW-1:0];
    n.col = nc[CW-1:0];
    return n;
  endfunction

  assign rows_eff = eff_limit(maze_rows, MAX_ROWS);
  assign cols_eff = eff_limit(maze_cols, MAX_COLS);
  assign look_n   = neighbour(nb[1:0], cur_row, cur_col, rows_eff, cols_eff);
  assign move_n   = neighbour(dir, cur_row, cur_col, rows_eff, cols_eff);
  assign can_emit = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign depth_dec = (depth != '0) ? depth - DW'(1) : depth;
  assign nb_prev  = nb - 3'd1;
  assign vis_raddr = {look_n.row, look_n.col};
  assign stk_raddr = SW'(depth_dec - DW'(1));

  // sequencer decisions
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_addr;
    vis_wdata = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = depth[SW-1:0];
    stk_wdata = {move_n.row, move_n.col};
    stk_re    = 1'b0;
    emit      = 1'b0;
    ev        = EV_REJECTED;
    wall      = DIR_EAST;
    unique case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_wdata = (clr_addr == '0);
        if (clr_addr == '0) begin
          // start cell goes to the bottom of the stack
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = '0;
          emit      = can_emit;
          ev        = EV_STARTED;
        end
      end
      S_DECIDE: begin
        if (!active) begin
          emit = can_emit;
        end else if (openv == 4'b0000) begin
          if (depth_dec == '0) begin
            emit = can_emit;
            ev   = EV_FINISHED;
          end else begin
            stk_re = 1'b1;
          end
        end else if (dir == DIR_SOUTH &&
                     LIM_W'(cur_row) == rows_eff - LIM_W'(1) && !exit_opened) begin
          emit = can_emit;
          ev   = EV_EXIT;
          wall = DIR_SOUTH;
        end else if (openv[dir]) begin
          emit      = can_emit;
          ev        = EV_CARVED;
          wall      = dir;
          vis_we    = can_emit;
          vis_waddr = {move_n.row, move_n.col};
          vis_wdata = 1'b1;
          stk_we    = can_emit && (depth < DW'(CELLS));
        end else begin
          emit = can_emit;
        end
      end
      S_POP: begin
        emit = can_emit;
        ev   = EV_BACKTRACKED;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis[vis_waddr] <= vis_wdata;
    end
    vis_q <= vis[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      maze_rows   <= REG_W'(32);
      maze_cols   <= REG_W'(32);
      cur_row     <= '0;
      cur_col     <= '0;
      depth       <= '0;
      exit_opened <= 1'b0;
      active      <= 1'b0;
      out_valid   <= 1'b0;
      nb          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ROWS: maze_rows <= cfg_data;
          REG_COLS: maze_cols <= cfg_data;
          default:  maze_rows <= maze_rows;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            dir <= direction;
            nb  <= '0;
            if (cmd_t'(command) == CMD_START) begin
              clr_addr <= '1;
              state    <= S_CLEAR;
            end else if (active) begin
              state <= S_LOOK;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_CLEAR: begin
          if (clr_addr != '0) begin
            clr_addr <= clr_addr - AW'(1);
          end else if (emit) begin
            cur_row     <= '0;
            cur_col     <= '0;
            depth       <= DW'(1);
            exit_opened <= 1'b0;
            active      <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_LOOK: begin
          look_ok <= look_n.ok;
          if (nb != '0) begin
            openv[nb_prev[1:0]] <= look_ok && !vis_q;
          end
          if (nb == 3'd4) begin
            state <= S_DECIDE;
          end
          nb <= nb + 3'd1;
        end
        S_DECIDE: begin
          if (stk_re) begin
            depth <= depth_dec;
            state <= S_POP;
          end else if (emit) begin
            state <= S_IDLE;
            unique case (ev)
              EV_FINISHED: begin
                depth  <= depth_dec;
                active <= 1'b0;
              end
              EV_EXIT: exit_opened <= 1'b1;
              EV_CARVED: begin
                cur_row <= move_n.row;
                cur_col <= move_n.col;
                if (depth < DW'(CELLS)) begin
                  depth <= depth + DW'(1);
                end
              end
              default: active <= active;
            endcase
          end
        end
        S_POP: begin
          if (emit) begin
            cur_row <= stk_q[AW-1:CW];
            cur_col <= stk_q[CW-1:0];
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      event_res      <= ev;
      wall_direction <= wall;
      unique case (ev)
        EV_CARVED: begin
          cell_row <= POS_W'(move_n.row);
          cell_col <= POS_W'(move_n.col);
        end
        EV_STARTED: begin
          cell_row <= '0;
          cell_col <= '0;
        end
        EV_BACKTRACKED: begin
          cell_row <= POS_W'(LIM_W'(stk_q[AW-1:CW]));
          cell_col <= POS_W'(LIM_W'(stk_q[CW-1:0]));
        end
        default: begin
          cell_row <= POS_W'(LIM_W'(cur_row));
          cell_col <= POS_W'(LIM_W'(cur_col));
        end
      endcase
    end
  end

endmodule
